@@ hdl/sgf_pkg.sv @@
// Shared constants, register indexes and interface structs for the gain/fade unit.
package sgf_pkg;

  localparam int SAMPLE_BITS_DEF = 16;
  localparam int FADE_BITS_DEF   = 24;
  localparam int GAIN_W          = 16;
  localparam int REG_IDX_W       = 3;

  localparam logic [GAIN_W-1:0] GAIN_UNITY = 16'h8000;
  localparam logic [1:0]        CH_MONO    = 2'd1;

  localparam logic [REG_IDX_W-1:0] REG_STREAM_VOLUME  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_MASTER_GAIN    = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_STREAM_MUTE    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_ALL_MUTE       = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_FADE_DIRECTION = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_FADE_LENGTH    = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_CHANNEL_COUNT  = 3'd6;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic gain;
    logic prod;
    logic mul_lo;
    logic mul_hi;
    logic div_step;
    logic finish;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;
  } dp_status_t;

  // register file -> datapath, per-frame settings
  typedef struct packed {
    logic [GAIN_W-1:0] stream_gain;
    logic [GAIN_W-1:0] master_gain;
    logic              muted;
    logic              mono;
    logic              active_after;
  } frame_cfg_t;

endpackage

@@ hdl/stereo_gain_fade_unit.sv @@
// Top level of the stereo gain and linear fade unit.
//
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------
//  cfg     | cfg_write            | cfg_index, cfg_data
//  in      | in_valid / in_ready  | left_sample, right_sample
//  out     | out_valid / out_ready| left_out, right_out, fade_running
//
// From accept to out_valid a frame runs through four setup steps, one quotient
// bit per cycle per channel in the restoring divider (SAMPLE_BITS + 1 bits,
// both channels side by side), and the finish step.
// in_ready is high only while the sequencer is idle; a finished item waits in
// the output register, so the next item can be taken while it is pending.
// A stalled output holds the sequencer in its last step until out_ready.
// rst is synchronous and returns the config, fade and control registers to
// their defaults; datapath work registers are loaded before use.
//
// Scaling per channel: q = (|s| * g * num + den*2^14) / (den*2^15), with
// g = stream gain * master gain in Q1.15, num/den the fade fraction (1/1 when
// no fade runs). Rounding is half away from zero, then saturate to signed.
module stereo_gain_fade_unit #(
  parameter int SAMPLE_BITS = sgf_pkg::SAMPLE_BITS_DEF,
  parameter int FADE_BITS   = sgf_pkg::FADE_BITS_DEF,
  localparam int CFG_W = (FADE_BITS > sgf_pkg::GAIN_W) ? FADE_BITS : sgf_pkg::GAIN_W
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [sgf_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]              cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] left_sample,
  input  logic signed [SAMPLE_BITS-1:0] right_sample,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] left_out,
  output logic signed [SAMPLE_BITS-1:0] right_out,
  output logic                          fade_running
);
  import sgf_pkg::*;

  dp_cmd_t              cmd;
  dp_status_t           status;
  frame_cfg_t           fcfg;
  logic [FADE_BITS-1:0] fade_num;
  logic [FADE_BITS-1:0] fade_den;

  // registers and fade state; fade advances when a frame retires while not muted
  sgf_regs #(
    .FADE_BITS (FADE_BITS),
    .CFG_W     (CFG_W)
  ) u_regs (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .frame_done (cmd.finish),
    .fcfg       (fcfg),
    .fade_num   (fade_num),
    .fade_den   (fade_den)
  );

  sgf_ctrl #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  sgf_dp #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .FADE_BITS   (FADE_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .fcfg         (fcfg),
    .fade_num     (fade_num),
    .fade_den     (fade_den),
    .left_sample  (left_sample),
    .right_sample (right_sample),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .left_out     (left_out),
    .right_out    (right_out),
    .fade_running (fade_running)
  );

endmodule

@@ hdl/sgf_regs.sv @@
// Configuration registers and fade position state.
module sgf_regs #(
  parameter int FADE_BITS = sgf_pkg::FADE_BITS_DEF,
  parameter int CFG_W     = (FADE_BITS > sgf_pkg::GAIN_W) ? FADE_BITS : sgf_pkg::GAIN_W
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [sgf_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]             cfg_data,
  input  logic                         frame_done,
  output sgf_pkg::frame_cfg_t          fcfg,
  output logic [FADE_BITS-1:0]         fade_num,
  output logic [FADE_BITS-1:0]         fade_den
);
  import sgf_pkg::*;

  logic [GAIN_W-1:0]    stream_volume;
  logic [GAIN_W-1:0]    master_gain;
  logic                 stream_mute;
  logic                 all_mute;
  logic                 fade_direction;
  logic [FADE_BITS-1:0] fade_length;
  logic [1:0]           channel_count;
  logic [FADE_BITS-1:0] fade_position;
  logic                 fade_active;
  logic                 faded_out;

  logic                 muted;
  logic                 fading;
  logic                 fade_end;
  logic [FADE_BITS-1:0] pos_inc;
  logic [FADE_BITS-1:0] pos_clamp;
  logic [GAIN_W-1:0]    wr_gain;

  always_comb begin
    muted     = stream_mute | all_mute;
    pos_inc   = fade_position + FADE_BITS'(1);
    fade_end  = (fade_length == '0) || (pos_inc >= fade_length);
    fading    = fade_active && (fade_length != '0);
    pos_clamp = (fade_position > fade_length) ? fade_length : fade_position;
    // no fade is the same as num/den = 1/1
    if (fading) begin
      fade_num = fade_direction ? pos_clamp : (fade_length - pos_clamp);
      fade_den = fade_length;
    end else begin
      fade_num = FADE_BITS'(1);
      fade_den = FADE_BITS'(1);
    end
    wr_gain = (cfg_data[GAIN_W-1:0] > GAIN_UNITY) ? GAIN_UNITY : cfg_data[GAIN_W-1:0];

    fcfg.stream_gain  = faded_out ? '0 : stream_volume;
    fcfg.master_gain  = master_gain;
    fcfg.muted        = muted;
    fcfg.mono         = (channel_count == CH_MONO);
    fcfg.active_after = fade_active && (muted || !fade_end);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stream_volume  <= GAIN_UNITY;
      master_gain    <= GAIN_UNITY;
      stream_mute    <= 1'b0;
      all_mute       <= 1'b0;
      fade_direction <= 1'b0;
      fade_length    <= '0;
      channel_count  <= 2'd2;
      fade_position  <= '0;
      fade_active    <= 1'b0;
      faded_out      <= 1'b0;
    end else begin
      if (frame_done && !muted && fade_active) begin
        fade_position <= pos_inc;
        if (fade_end) begin
          fade_active <= 1'b0;
          if (!fade_direction) begin
            faded_out <= 1'b1;
          end
        end
      end
      if (cfg_write) begin
        unique case (cfg_index)
          REG_STREAM_VOLUME: begin
            stream_volume <= cfg_data[GAIN_W-1:0];
            fade_active   <= 1'b0;
            faded_out     <= 1'b0;
          end
          REG_MASTER_GAIN: begin
            master_gain <= wr_gain;
          end
          REG_STREAM_MUTE: begin
            stream_mute <= cfg_data[0];
            fade_active <= 1'b0;
          end
          REG_ALL_MUTE: begin
            all_mute <= cfg_data[0];
          end
          REG_FADE_DIRECTION: begin
            fade_direction <= cfg_data[0];
          end
          REG_FADE_LENGTH: begin
            fade_length   <= cfg_data[FADE_BITS-1:0];
            fade_position <= '0;
            fade_active   <= (cfg_data[FADE_BITS-1:0] != '0);
          end
          REG_CHANNEL_COUNT: begin
            channel_count <= cfg_data[1:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

@@ hdl/sgf_dp.sv @@
// Datapath: gain product, fade multiply, restoring divider and output register.
module sgf_dp #(
  parameter int SAMPLE_BITS = sgf_pkg::SAMPLE_BITS_DEF,
  parameter int FADE_BITS   = sgf_pkg::FADE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  sgf_pkg::dp_cmd_t              cmd,
  output sgf_pkg::dp_status_t           status,
  input  sgf_pkg::frame_cfg_t           fcfg,
  input  logic [FADE_BITS-1:0]          fade_num,
  input  logic [FADE_BITS-1:0]          fade_den,
  input  logic signed [SAMPLE_BITS-1:0] left_sample,
  input  logic signed [SAMPLE_BITS-1:0] right_sample,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] left_out,
  output logic signed [SAMPLE_BITS-1:0] right_out,
  output logic                          fade_running
);
  import sgf_pkg::*;

  localparam int SB = SAMPLE_BITS;
  localparam int PW = SB + 15;             // |s| * g
  localparam int NL = (FADE_BITS + 1) / 2; // low half of the fade numerator
  localparam int NU = FADE_BITS - NL;
  localparam int AW = PW + NL;
  localparam int HW = PW + NU;
  localparam int NW = SB + FADE_BITS + 16; // dividend
  localparam int DW = FADE_BITS + 15;      // divisor = den << 15
  localparam int QB = SB + 1;              // quotient bits
  localparam logic [QB-1:0] NEG_LIM = {2'b01, {(SB-1){1'b0}}};
  localparam logic [QB-1:0] POS_MAX = NEG_LIM - QB'(1);

  logic [GAIN_W-1:0] g;
  logic [SB-1:0]     mag   [2];
  logic              neg   [2];
  logic [PW-1:0]     prod  [2];
  logic [AW-1:0]     acc   [2];
  logic [DW-1:0]     rem   [2];
  logic [QB-1:0]     dlo   [2];
  logic [QB-1:0]     quo   [2];

  logic [2*GAIN_W-1:0] gprod;
  logic [2*GAIN_W-1:0] gsum;
  logic [DW-1:0]       divisor;
  logic [SB-1:0]       smp     [2];
  logic [SB-1:0]       smag    [2];
  logic [PW-1:0]       mg_prod [2];
  logic [AW-1:0]       lo_prod [2];
  logic [HW-1:0]       hi_prod [2];
  logic [NW-1:0]       nsum    [2];
  logic [DW:0]         trial   [2];
  logic [DW:0]         diff    [2];
  logic                ge      [2];
  logic [SB-1:0]       sat     [2];

  always_comb begin
    gprod   = fcfg.stream_gain * fcfg.master_gain;
    gsum    = gprod + (2*GAIN_W)'(16384);
    divisor = {fade_den, 15'b0};
    smp[0]  = left_sample;
    smp[1]  = right_sample;
    for (int i = 0; i < 2; i++) begin
      smag[i]    = smp[i][SB-1] ? (~smp[i] + SB'(1)) : smp[i];
      mg_prod[i] = mag[i] * g;
      lo_prod[i] = prod[i] * fade_num[NL-1:0];
      hi_prod[i] = prod[i] * fade_num[FADE_BITS-1:NL];
      // |s|*g*num + den*2^14, the rounding half
      nsum[i]    = NW'(acc[i]) + (NW'(hi_prod[i]) << NL) + NW'({fade_den, 14'b0});
      trial[i]   = {rem[i], dlo[i][QB-1]};
      diff[i]    = trial[i] - {1'b0, divisor};
      ge[i]      = (trial[i] >= {1'b0, divisor});
      if (neg[i]) begin
        sat[i] = (quo[i] > NEG_LIM) ? NEG_LIM[SB-1:0] : (~quo[i][SB-1:0] + SB'(1));
      end else begin
        sat[i] = (quo[i] > POS_MAX) ? POS_MAX[SB-1:0] : quo[i][SB-1:0];
      end
    end
    status.out_free = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.gain) begin
      g <= gsum[GAIN_W+14:15];
    end
    for (int i = 0; i < 2; i++) begin
      if (cmd.load) begin
        mag[i] <= smag[i];
        neg[i] <= smp[i][SB-1];
      end
      if (cmd.prod) begin
        prod[i] <= mg_prod[i];
      end
      if (cmd.mul_lo) begin
        acc[i] <= lo_prod[i];
      end
      if (cmd.mul_hi) begin
        rem[i] <= nsum[i][NW-1:QB];
        dlo[i] <= nsum[i][QB-1:0];
      end else if (cmd.div_step) begin
        rem[i] <= ge[i] ? diff[i][DW-1:0] : trial[i][DW-1:0];
        dlo[i] <= {dlo[i][QB-2:0], 1'b0};
        quo[i] <= {quo[i][QB-2:0], ge[i]};
      end
    end
    if (cmd.finish) begin
      left_out     <= fcfg.muted ? '0 : sat[0];
      right_out    <= (fcfg.muted || fcfg.mono) ? '0 : sat[1];
      fade_running <= fcfg.active_after;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

@@ hdl/sgf_ctrl.sv @@
// Sequencer that steps one frame through the datapath.
module sgf_ctrl #(
  parameter int SAMPLE_BITS = sgf_pkg::SAMPLE_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  sgf_pkg::dp_status_t status,
  output sgf_pkg::dp_cmd_t    cmd
);
  import sgf_pkg::*;

  localparam int QB    = SAMPLE_BITS + 1;
  localparam int CNT_W = $clog2(QB);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_GAIN   = 3'd1;
  localparam logic [2:0] ST_PROD   = 3'd2;
  localparam logic [2:0] ST_MUL_LO = 3'd3;
  localparam logic [2:0] ST_MUL_HI = 3'd4;
  localparam logic [2:0] ST_DIV    = 3'd5;
  localparam logic [2:0] ST_DONE   = 3'd6;

  logic [2:0]       state;
  logic [2:0]       state_next;
  logic [CNT_W-1:0] count;

  always_comb begin
    in_ready     = (state == ST_IDLE);
    cmd.load     = (state == ST_IDLE) && in_valid;
    cmd.gain     = (state == ST_GAIN);
    cmd.prod     = (state == ST_PROD);
    cmd.mul_lo   = (state == ST_MUL_LO);
    cmd.mul_hi   = (state == ST_MUL_HI);
    cmd.div_step = (state == ST_DIV);
    cmd.finish   = (state == ST_DONE) && status.out_free;

    state_next = state;
    unique case (state)
      ST_IDLE:   if (in_valid) state_next = ST_GAIN;
      ST_GAIN:   state_next = ST_PROD;
      ST_PROD:   state_next = ST_MUL_LO;
      ST_MUL_LO: state_next = ST_MUL_HI;
      ST_MUL_HI: state_next = ST_DIV;
      ST_DIV:    if (count == '0) state_next = ST_DONE;
      ST_DONE:   if (status.out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (state == ST_MUL_HI) begin
        count <= CNT_W'(QB - 1);
      end else if (state == ST_DIV) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

@@ hdl/sgf_check.sv @@
// Port-level checker for the gain/fade unit, bound to the top level.
module sgf_check #(
  parameter int SAMPLE_BITS = sgf_pkg::SAMPLE_BITS_DEF
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic signed [SAMPLE_BITS-1:0] left_out,
  input logic signed [SAMPLE_BITS-1:0] right_out,
  input logic                          fade_running
);

  // items accepted but not yet delivered
  logic [1:0] pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 2'(in_valid && in_ready) - 2'(out_valid && out_ready);
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("in_ready stayed high after an item was accepted");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != 2'd0)
    else $error("result shown with no item outstanding");

  a_room: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> pending <= 2'd1)
    else $error("ready while two items are outstanding");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(left_out) && $stable(right_out)
      && $stable(fade_running))
    else $error("stalled result changed");

endmodule

bind stereo_gain_fade_unit sgf_check #(.SAMPLE_BITS(SAMPLE_BITS)) u_check (.*);

@@ tb/tb.sv @@
// Self-checking testbench for the stereo gain and linear fade unit.
module tb;
  import sgf_pkg::*;

  localparam int SW = SAMPLE_BITS_DEF;
  localparam int FW = FADE_BITS_DEF;
  localparam int CW = (FW > GAIN_W) ? FW : GAIN_W;

  localparam longint SMAX = (64'sd1 <<< (SW - 1)) - 1;
  localparam longint SMIN = -SMAX - 1;

  // Index past the last register: the block must drop such writes.
  localparam logic [REG_IDX_W-1:0] REG_NONE = 3'd7;

  // Stimulus sizing and run limits.
  localparam int RANDOM_FRAMES = 1550;
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int MAX_REPORTS   = 10;
  localparam int IDLE_PCT      = 17;

  typedef struct packed {
    logic signed [SW-1:0] left;
    logic signed [SW-1:0] right;
    logic                 running;
  } frame_t;

  typedef enum {ROW_WRITE, ROW_FRAME, ROW_KNOWN} row_kind_t;

  typedef struct {
    row_kind_t            kind;
    logic [REG_IDX_W-1:0] idx;
    logic [CW-1:0]        data;
    logic signed [SW-1:0] l;
    logic signed [SW-1:0] r;
    frame_t               res;
  } script_row_t;

  // All block inputs start at known values.
  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_write = 1'b0;
  logic [REG_IDX_W-1:0] cfg_index = '0;
  logic [CW-1:0]        cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic signed [SW-1:0] left_sample = '0;
  logic signed [SW-1:0] right_sample = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic signed [SW-1:0] left_out;
  logic signed [SW-1:0] right_out;
  logic                 fade_running;

  stereo_gain_fade_unit uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .left_sample  (left_sample),
    .right_sample (right_sample),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .left_out     (left_out),
    .right_out    (right_out),
    .fade_running (fade_running)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow copy of the register file and fade state, kept in step with the
  // block: registers update on each write, fade state on each accepted unmuted frame.
  logic [GAIN_W-1:0] sh_volume;
  logic [GAIN_W-1:0] sh_mgain;
  logic              sh_smute;
  logic              sh_mmute;
  logic              sh_fdir;
  logic [FW-1:0]     sh_flen;
  logic [1:0]        sh_chans;
  logic [FW-1:0]     fade_pos;
  logic              fade_on;
  logic              fade_done;   // finished fade-out: stream gain forced to zero

  frame_t      expected_frames[$];
  script_row_t script[$];

  int  fail_count = 0;
  int  cycle_count = 0;
  bit  idle_in = 1'b1;
  bit  stall_out = 1'b1;

  task automatic reset_shadow();
    sh_volume = GAIN_UNITY;
    sh_mgain  = GAIN_UNITY;
    sh_smute  = 1'b0;
    sh_mmute  = 1'b0;
    sh_fdir   = 1'b0;
    sh_flen   = '0;
    sh_chans  = 2'd2;
    fade_pos  = '0;
    fade_on   = 1'b0;
    fade_done = 1'b0;
  endtask

  task automatic apply_reg(input logic [REG_IDX_W-1:0] idx, input logic [CW-1:0] data);
    case (idx)
      REG_STREAM_VOLUME: begin
        sh_volume = data[GAIN_W-1:0];
        fade_on   = 1'b0;
        fade_done = 1'b0;
      end
      REG_MASTER_GAIN: begin
        sh_mgain = (data[GAIN_W-1:0] > GAIN_UNITY) ? GAIN_UNITY : data[GAIN_W-1:0];
      end
      REG_STREAM_MUTE: begin
        sh_smute = data[0];
        fade_on  = 1'b0;
      end
      REG_ALL_MUTE:       sh_mmute = data[0];
      REG_FADE_DIRECTION: sh_fdir  = data[0];
      REG_FADE_LENGTH: begin
        sh_flen  = data[FW-1:0];
        fade_pos = '0;
        fade_on  = (data[FW-1:0] != 0);
      end
      REG_CHANNEL_COUNT:  sh_chans = data[1:0];
      default: ;
    endcase
  endtask

  // |s| * gain * num / den, rounded half away from zero, then saturated.
  function automatic logic signed [SW-1:0] scale_sample(input logic signed [SW-1:0] s,
      input longint unsigned gain, input longint unsigned num, input longint unsigned den);
    longint          sval;
    longint unsigned mag;
    longint unsigned q;
    longint          res;
    sval = s;
    mag  = (sval < 0) ? longint'(-sval) : longint'(sval);
    q    = (mag * gain * num + den / 2) / den;
    if (sval < 0)
      res = (q > longint'(-SMIN)) ? SMIN : -longint'(q);
    else
      res = (q > longint'(SMAX)) ? SMAX : longint'(q);
    return res[SW-1:0];
  endfunction

  // Expected output for one accepted frame; advances the shadow fade state.
  task automatic predict_frame(input logic signed [SW-1:0] l, input logic signed [SW-1:0] r,
      output frame_t res);
    longint unsigned vol;
    longint unsigned gain;
    longint unsigned num;
    longint unsigned den;
    longint unsigned pos;
    if (sh_smute || sh_mmute) begin
      // muted frames leave the fade where it is
      res.left    = '0;
      res.right   = '0;
      res.running = fade_on;
    end else begin
      vol  = fade_done ? 0 : sh_volume;
      gain = (vol * sh_mgain + 16384) >> 15;
      num  = 1;
      den  = GAIN_UNITY;
      if (fade_on && sh_flen != 0) begin
        pos = (fade_pos > sh_flen) ? sh_flen : fade_pos;
        num = sh_fdir ? pos : longint'(sh_flen) - pos;
        den = longint'(sh_flen) * GAIN_UNITY;
      end
      res.left  = scale_sample(l, gain, num, den);
      res.right = (sh_chans == CH_MONO) ? '0 : scale_sample(r, gain, num, den);
      if (fade_on) begin
        fade_pos = fade_pos + 1'b1;
        if (sh_flen == 0 || fade_pos >= sh_flen) begin
          fade_on = 1'b0;
          if (!sh_fdir)
            fade_done = 1'b1;
        end
      end
      res.running = fade_on;
    end
  endtask

  // Register write; cfg_write is left high so back-to-back writes need no
  // second assignment in one step. The next frame lowers it.
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CW-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    apply_reg(idx, data);
  endtask

  // Offer one frame and hold it until taken. Valid stays high on return so the
  // next frame can follow back to back.
  task automatic send_frame(input logic signed [SW-1:0] l, input logic signed [SW-1:0] r,
      input bit known, input frame_t known_res);
    frame_t res;
    cfg_write <= 1'b0;
    if (idle_in && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 40);
    end
    in_valid     <= 1'b1;
    left_sample  <= l;
    right_sample <= r;
    do @(posedge clk); while (!in_ready);
    predict_frame(l, r, res);
    expected_frames.push_back(known ? known_res : res);
  endtask

  // Stop sending and wait until every expected frame has come out, so the
  // block is idle. Polling on the falling edge keeps clear of the checker.
  task automatic wait_all_out();
    in_valid <= 1'b0;
    while (expected_frames.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  function automatic logic signed [SW-1:0] rand_sample();
    case ($urandom_range(9))
      0:       return SMAX[SW-1:0];
      1:       return SMIN[SW-1:0];
      2:       return '0;
      3:       return {SW{1'b1}};
      default: return SW'($urandom);
    endcase
  endfunction

  function automatic logic [CW-1:0] rand_reg_value(input logic [REG_IDX_W-1:0] idx);
    logic [CW-1:0] v;
    // stray upper bits now and then; the block must ignore them
    v = ($urandom_range(3) == 0) ? CW'($urandom) : '0;
    case (idx)
      REG_STREAM_VOLUME, REG_MASTER_GAIN: begin
        case ($urandom_range(5))
          0:       v[GAIN_W-1:0] = '0;
          1:       v[GAIN_W-1:0] = '1;
          2:       v[GAIN_W-1:0] = GAIN_UNITY;
          default: v[GAIN_W-1:0] = GAIN_W'($urandom);
        endcase
      end
      REG_STREAM_MUTE, REG_ALL_MUTE: v[0] = ($urandom_range(99) < 25);
      REG_FADE_DIRECTION:            v[0] = 1'($urandom_range(1));
      REG_CHANNEL_COUNT:             v[1:0] = 2'($urandom_range(3));
      REG_FADE_LENGTH: begin
        // mostly short fades so they run to completion within a phase
        case ($urandom_range(19))
          0:       v = '0;
          1:       v = {FW{1'b1}};
          2:       v = CW'($urandom);
          3, 4, 5: v = CW'($urandom_range(21, 200));
          default: v = CW'($urandom_range(1, 20));
        endcase
      end
      default: v = CW'($urandom);
    endcase
    return v;
  endfunction

  function automatic void add_write(input logic [REG_IDX_W-1:0] idx, input logic [CW-1:0] data);
    script.push_back('{ROW_WRITE, idx, data, '0, '0, '0});
  endfunction

  function automatic void add_frame(input logic signed [SW-1:0] l,
      input logic signed [SW-1:0] r);
    script.push_back('{ROW_FRAME, '0, '0, l, r, '0});
  endfunction

  function automatic void add_known(input logic signed [SW-1:0] l,
      input logic signed [SW-1:0] r, input logic signed [SW-1:0] el,
      input logic signed [SW-1:0] er, input logic erun);
    script.push_back('{ROW_KNOWN, '0, '0, l, r, '{el, er, erun}});
  endfunction

  // Receiver: random back-pressure unless the quiet stretch is on.
  always @(posedge clk) begin
    out_ready <= !(stall_out && $urandom_range(99) < IDLE_PCT);
  end

  // Output checker: every taken result is compared with the oldest expected one.
  always @(posedge clk) begin : result_check
    frame_t exp_f;
    if (!rst && out_valid && out_ready) begin
      if (expected_frames.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("unexpected item: left %0d right %0d running %0b",
                   left_out, right_out, fade_running);
      end else begin
        exp_f = expected_frames.pop_front();
        if (left_out !== exp_f.left || right_out !== exp_f.right ||
            fade_running !== exp_f.running) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("mismatch: left %0d/%0d right %0d/%0d running %0b/%0b (exp/got)",
                     exp_f.left, left_out, exp_f.right, right_out,
                     exp_f.running, fade_running);
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin : stimulus
    bit   in_writes;
    int   frames_sent;
    int   nwr;
    int   nframes;
    bit   quiet;
    logic [REG_IDX_W-1:0] idx;

    reset_shadow();

    // Directed script. After reset the gain is exactly unity, so samples
    // pass through unchanged; known rows carry their obvious results.
    add_known(0, 0, 0, 0, 1'b0);
    add_known(SMAX, SMIN, SMAX, SMIN, 1'b0);
    add_known(-1, 1, -1, 1, 1'b0);
    add_known(16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA, 1'b0);
    // top stream gain saturates the extremes
    add_write(REG_STREAM_VOLUME, 24'hFFFF);
    add_known(SMAX, SMIN, SMAX, SMIN, 1'b0);
    add_frame(-12345, 23456);
    // master gain above unity is clamped
    add_write(REG_MASTER_GAIN, 24'hFFFF);
    add_frame(1000, -1000);
    add_write(REG_MASTER_GAIN, 24'h0);
    add_known(SMAX, SMIN, 0, 0, 1'b0);
    add_write(REG_MASTER_GAIN, CW'(GAIN_UNITY));
    add_write(REG_STREAM_VOLUME, CW'(GAIN_UNITY));
    // only a channel count of one means mono
    add_write(REG_CHANNEL_COUNT, 24'd1);
    add_known(1234, 5678, 1234, 0, 1'b0);
    add_write(REG_CHANNEL_COUNT, 24'd0);
    add_known(1234, 5678, 1234, 5678, 1'b0);
    add_write(REG_CHANNEL_COUNT, 24'd3);
    add_known(1234, 5678, 1234, 5678, 1'b0);
    add_write(REG_CHANNEL_COUNT, 24'd2);
    // mutes
    add_write(REG_STREAM_MUTE, 24'd1);
    add_known(500, -500, 0, 0, 1'b0);
    add_write(REG_STREAM_MUTE, 24'd0);
    add_write(REG_ALL_MUTE, 24'd1);
    add_known(500, -500, 0, 0, 1'b0);
    add_write(REG_ALL_MUTE, 24'd0);
    // fade-out of four frames; master mute holds it first
    add_write(REG_FADE_DIRECTION, 24'd0);
    add_write(REG_FADE_LENGTH, 24'd4);
    add_write(REG_ALL_MUTE, 24'd1);
    add_known(8000, -8000, 0, 0, 1'b1);
    add_write(REG_ALL_MUTE, 24'd0);
    // runs down, ends, then stays silent
    repeat (5) add_frame(8000, -8000);
    // stream volume write lifts the silence; then a fade-in of three
    add_write(REG_STREAM_VOLUME, CW'(GAIN_UNITY));
    add_write(REG_FADE_DIRECTION, 24'd1);
    add_write(REG_FADE_LENGTH, 24'd3);
    repeat (4) add_frame(30000, -30000);
    // a stream mute write cancels a running fade
    add_write(REG_FADE_LENGTH, 24'd5);
    add_frame(9999, -9999);
    add_write(REG_STREAM_MUTE, 24'd0);
    add_frame(9999, -9999);
    // longest fade; an out-of-range index is dropped; length zero stops it
    add_write(REG_FADE_LENGTH, {FW{1'b1}});
    add_frame(SMAX, SMIN);
    add_write(REG_NONE, 24'h1234);
    add_write(REG_FADE_LENGTH, 24'd0);
    add_frame(SMIN, SMAX);

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    in_writes = 1'b0;
    foreach (script[i]) begin
      if (script[i].kind == ROW_WRITE) begin
        if (!in_writes) begin
          wait_all_out();
          in_writes = 1'b1;
        end
        write_reg(script[i].idx, script[i].data);
      end else begin
        in_writes = 1'b0;
        send_frame(script[i].l, script[i].r, script[i].kind == ROW_KNOWN, script[i].res);
      end
    end

    // Random phases: drain, reprogram a few registers (often a new fade),
    // then a burst of frames. One stretch runs with no idling on either side.
    frames_sent = 0;
    while (frames_sent < RANDOM_FRAMES) begin
      wait_all_out();
      quiet     = (frames_sent >= 600 && frames_sent < 850);
      idle_in   = !quiet;
      stall_out = !quiet;
      nwr = $urandom_range(0, 3);
      repeat (nwr) begin
        idx = REG_IDX_W'($urandom_range(0, 7));
        write_reg(idx, rand_reg_value(idx));
      end
      if ($urandom_range(99) < 55)
        write_reg(REG_FADE_LENGTH, rand_reg_value(REG_FADE_LENGTH));
      nframes = $urandom_range(6, 50);
      repeat (nframes) begin
        send_frame(rand_sample(), rand_sample(), 1'b0, '0);
        frames_sent++;
      end
    end

    wait_all_out();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && expected_frames.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
